@@ rtl/gemini_header_parser_assert.svh @@
// Assertion macros for the header parser.
`ifndef GEMINI_HEADER_PARSER_ASSERT_SVH
`define GEMINI_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define GHP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("header parser check failed");

`define GHP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("header parser check failed");

`else

`define GHP_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define GHP_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

@@ rtl/ghp_pkg.sv @@
package ghp_pkg;

  localparam int unsigned LEN_W = 11;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1027;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic KIND_META    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
  localparam logic [1:0] VERDICT_FRAMING   = 2'd2;

  // range rule for the next continuation byte
  localparam logic [2:0] RULE_ANY   = 3'd0;
  localparam logic [2:0] RULE_AFTER_E0 = 3'd1;
  localparam logic [2:0] RULE_AFTER_ED = 3'd2;
  localparam logic [2:0] RULE_AFTER_F0 = 3'd3;
  localparam logic [2:0] RULE_AFTER_F4 = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] meta_byte;
    logic [1:0] verdict;
    logic [6:0] status_code;
  } res_t;

endpackage

@@ rtl/ghp_core.sv @@
`include "gemini_header_parser_assert.svh"

module ghp_core
  import ghp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  item_t            item,
  input  logic [LEN_W-1:0] max_len,
  output res_t             res
);

  logic [LEN_W-1:0] byte_count_r, byte_count_nxt;
  logic [3:0]       status_tens_r, status_tens_nxt;
  logic [3:0]       status_units_r, status_units_nxt;
  logic [1:0]       utf8_remaining_r, utf8_remaining_nxt;
  logic [2:0]       utf8_rule_r, utf8_rule_nxt;
  logic             c1_lead_r, c1_lead_nxt;
  logic             pending_r, pending_nxt;
  logic             malformed_r, malformed_nxt;

  logic [7:0]       b;
  logic [7:0]       digit;
  logic [7:0]       status_sum;
  logic [LEN_W:0]   effective;
  logic [LEN_W-1:0] pos;
  logic [7:0]       lo;
  logic [7:0]       hi;
  logic             give;
  logic [1:0]       give_verdict;

  assign b          = item.data_byte;
  assign digit      = b - CH_ZERO;
  assign status_sum = {1'b0, status_tens_r, 3'b000} + {3'b000, status_tens_r, 1'b0}
                    + {4'b0000, status_units_r};
  assign effective  = {1'b0, byte_count_r} + {{LEN_W{1'b0}}, pending_r};

  always_comb begin
    byte_count_nxt     = byte_count_r;
    status_tens_nxt    = status_tens_r;
    status_units_nxt   = status_units_r;
    utf8_remaining_nxt = utf8_remaining_r;
    utf8_rule_nxt      = utf8_rule_r;
    c1_lead_nxt        = c1_lead_r;
    pending_nxt        = pending_r;
    malformed_nxt      = malformed_r;
    pos                = byte_count_r;
    lo                 = 8'h80;
    hi                 = 8'hBF;
    give               = 1'b0;
    give_verdict       = VERDICT_ACCEPTED;
    res                = '0;

    if (fire) begin
      if (item.command == CMD_EOS || b == CH_NUL) begin
        give         = 1'b1;
        give_verdict = VERDICT_FRAMING;
      end else if (b == CH_LF) begin
        give = 1'b1;
        if (!pending_r) begin
          give_verdict = VERDICT_FRAMING;
        end else if (byte_count_r < 11'd2 || malformed_r || utf8_remaining_r != 2'd0 ||
                     (byte_count_r == 11'd2 && status_tens_r < 4'd4)) begin
          give_verdict = VERDICT_MALFORMED;
        end else begin
          give_verdict = VERDICT_ACCEPTED;
        end
      end else if (effective > {1'b0, max_len} ||
                   (effective == {1'b0, max_len} && b != CH_CR)) begin
        give         = 1'b1;
        give_verdict = VERDICT_FRAMING;
      end else begin
        if (pending_r) begin
          malformed_nxt  = 1'b1;
          pending_nxt    = 1'b0;
          byte_count_nxt = byte_count_r + 11'd1;
        end
        if (b == CH_CR) begin
          pending_nxt = 1'b1;
        end else begin
          pos = byte_count_nxt;
          if (pos == 11'd0) begin
            if (b < CH_ONE || b > CH_SIX) malformed_nxt = 1'b1;
            status_tens_nxt = digit[3:0];
          end else if (pos == 11'd1) begin
            if (b < CH_ZERO || b > CH_NINE) malformed_nxt = 1'b1;
            status_units_nxt = digit[3:0];
          end else if (pos == 11'd2) begin
            if (b != CH_SPACE) malformed_nxt = 1'b1;
          end

          // UTF-8 decoder
          if (b[7:6] == 2'b10) begin
            case (utf8_rule_r)
              RULE_AFTER_E0: lo = 8'hA0;
              RULE_AFTER_ED: hi = 8'h9F;
              RULE_AFTER_F0: lo = 8'h90;
              RULE_AFTER_F4: hi = 8'h8F;
              default: begin
              end
            endcase
            if (utf8_remaining_r == 2'd0 || b < lo || b > hi) begin
              malformed_nxt      = 1'b1;
              utf8_remaining_nxt = 2'd0;
            end else begin
              if (c1_lead_r && b <= 8'h9F) malformed_nxt = 1'b1;
              utf8_remaining_nxt = utf8_remaining_r - 2'd1;
            end
            utf8_rule_nxt = RULE_ANY;
            c1_lead_nxt   = 1'b0;
          end else begin
            if (utf8_remaining_r != 2'd0) malformed_nxt = 1'b1;
            utf8_remaining_nxt = 2'd0;
            utf8_rule_nxt      = RULE_ANY;
            c1_lead_nxt        = 1'b0;
            if (!b[7]) begin
              if (b < CH_SPACE || b == CH_DEL) malformed_nxt = 1'b1;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
              utf8_remaining_nxt = 2'd1;
              c1_lead_nxt        = (b == 8'hC2);
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
              utf8_remaining_nxt = 2'd2;
              if (b == 8'hE0)      utf8_rule_nxt = RULE_AFTER_E0;
              else if (b == 8'hED) utf8_rule_nxt = RULE_AFTER_ED;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
              utf8_remaining_nxt = 2'd3;
              if (b == 8'hF0)      utf8_rule_nxt = RULE_AFTER_F0;
              else if (b == 8'hF4) utf8_rule_nxt = RULE_AFTER_F4;
            end else begin
              malformed_nxt = 1'b1;
            end
          end

          byte_count_nxt = byte_count_nxt + 11'd1;
          if (pos >= 11'd3) begin
            res.valid     = 1'b1;
            res.kind      = KIND_META;
            res.meta_byte = b;
          end
        end
      end

      if (give) begin
        res.valid   = 1'b1;
        res.kind    = KIND_VERDICT;
        res.verdict = give_verdict;
        if (give_verdict == VERDICT_ACCEPTED) res.status_code = status_sum[6:0];
        byte_count_nxt     = '0;
        status_tens_nxt    = '0;
        status_units_nxt   = '0;
        utf8_remaining_nxt = '0;
        utf8_rule_nxt      = RULE_ANY;
        c1_lead_nxt        = 1'b0;
        pending_nxt        = 1'b0;
        malformed_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      status_tens_r    <= '0;
      status_units_r   <= '0;
      utf8_remaining_r <= '0;
      utf8_rule_r      <= RULE_ANY;
      c1_lead_r        <= 1'b0;
      pending_r        <= 1'b0;
      malformed_r      <= 1'b0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      status_tens_r    <= status_tens_nxt;
      status_units_r   <= status_units_nxt;
      utf8_remaining_r <= utf8_remaining_nxt;
      utf8_rule_r      <= utf8_rule_nxt;
      c1_lead_r        <= c1_lead_nxt;
      pending_r        <= pending_nxt;
      malformed_r      <= malformed_nxt;
    end
  end

  `GHP_ASSERT_IMPL(a_c1_needs_one_left, clk, rst_n, c1_lead_r, utf8_remaining_r == 2'd1)
  `GHP_ASSERT_IMPL(a_rule_needs_multi, clk, rst_n, utf8_rule_r != RULE_ANY,
                   utf8_remaining_r == 2'd2 || utf8_remaining_r == 2'd3)
  `GHP_ASSERT_NEXT(a_verdict_clears, clk, rst_n, res.valid && res.kind == KIND_VERDICT,
                   byte_count_r == '0 && !pending_r && !malformed_r)

endmodule

@@ rtl/gemini_header_parser.sv @@
// Gemini response header checker. Each beat is a header byte or an end-of-stream
// command; bytes from position 3 on come out as meta beats, and the final CRLF,
// a framing error or end of stream gives one verdict beat, status code if accepted.
// One beat can be taken every cycle unless a result is stalled: a beat is held in
// the input register, then the step logic updates the per-header state and loads
// the result register, from which the result is offered. A stalled result holds
// the step logic, and with it the input register, until it is taken.
// cfg_wdata sets the longest header allowed before the CRLF (1027 after reset);
// the user must see it is written only while idle, as the block does not enforce it.
`include "gemini_header_parser_assert.svh"

module gemini_header_parser
  import ghp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [7:0]       out_meta_byte,
  output logic [1:0]       out_verdict,
  output logic [6:0]       out_status_code,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic             in_valid_r, in_valid_nxt;
  item_t            item_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r;
  logic [LEN_W-1:0] max_len_r;
  logic             step_fire;
  res_t             res;

  assign step_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (step_fire) in_valid_nxt = 1'b0;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (step_fire && res.valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command   <= in_command;
      item_r.data_byte <= in_data_byte;
    end
    if (step_fire && res.valid) res_r <= res;
  end

  ghp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (step_fire),
    .item    (item_r),
    .max_len (max_len_r),
    .res     (res)
  );

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_meta_byte   = res_r.meta_byte;
  assign out_verdict     = res_r.verdict;
  assign out_status_code = res_r.status_code;

  `GHP_ASSERT_IMPL(a_verdict_code_legal, clk, rst_n, out_valid_r,
                   out_verdict != 2'd3)
  `GHP_ASSERT_IMPL(a_accepted_status_range, clk, rst_n,
                   out_valid_r && out_kind == KIND_VERDICT && out_verdict == VERDICT_ACCEPTED,
                   out_status_code >= 7'd10 && out_status_code <= 7'd69)
  `GHP_ASSERT_IMPL(a_meta_beat_clean, clk, rst_n, out_valid_r && out_kind == KIND_META,
                   out_verdict == VERDICT_ACCEPTED && out_status_code == 7'd0)

endmodule
